// ----- rtl/bpc_pkg.sv -----
// Shared types, constants and step functions of the background pixel compositor.
package bpc_pkg;

   // Field widths
   localparam int COORD_W  = 13;
   localparam int DIM_W    = 14;
   localparam int MARGIN_W = 12;
   localparam int PIX_W    = 32;
   localparam int CHAN_W   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int REGION_W = 2;

   // Frame sizes above this saturate
   localparam int MAX_DIM = 8192;
   localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(MAX_DIM);

   // Signed bound width, distance and square-root widths
   localparam int LIM_W   = DIM_W + 1;
   localparam int DIST_W  = MARGIN_W;
   localparam int SQ_W    = 2 * DIST_W;
   localparam int SUM_W   = SQ_W + 1;
   localparam int ROOT_W  = (SUM_W + 1) / 2;
   localparam int REM_W   = SUM_W;
   localparam int RACC_W  = SUM_W + 1;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int ROOT_TOP   = 2 * (ROOT_STEPS - 1);

   // Step divider for the alpha ramp
   localparam int DIV_STEPS = CHAN_W;

   // Iterations folded into one pipeline stage
   localparam int STEPS_PER_STAGE = 2;
   localparam int ROOT_STAGES = (ROOT_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH     = 3'd0,
      CSR_FRAME_HEIGHT    = 3'd1,
      CSR_MARGIN_WIDTH    = 3'd2,
      CSR_GRADIENT_WIDTH  = 3'd3,
      CSR_BG_COLOUR       = 3'd4,
      CSR_BACKDROP_COLOUR = 3'd5
   } csr_index_type;

   // Region codes on the result channel
   typedef enum logic [REGION_W-1:0] {
      REGION_OUTER = 2'd0,
      REGION_RING  = 2'd1,
      REGION_INNER = 2'd2
   } region_type;

   // Reset values of the configuration registers
   localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 14'd1024;
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 14'd768;

   typedef struct packed {
      logic [DIM_W-1:0]    frame_width;
      logic [DIM_W-1:0]    frame_height;
      logic [MARGIN_W-1:0] margin_width;
      logic [MARGIN_W-1:0] gradient_width;
      logic [PIX_W-1:0]    bg_colour;
      logic [PIX_W-1:0]    backdrop_colour;
   } cfg_type;

   // Frame bounds of one item, two's complement in LIM_W bits
   typedef struct packed {
      logic [LIM_W-1:0]    xm;
      logic [LIM_W-1:0]    ym;
      logic [LIM_W-1:0]    xn;
      logic [LIM_W-1:0]    yn;
      logic [MARGIN_W-1:0] n;
   } lim_type;

   // Per-item data that rides beside the square root
   typedef struct packed {
      logic [PIX_W-1:0]  pix;
      region_type        region;
      logic              corner;
      logic [DIST_W-1:0] lin_dist;
   } side_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [RACC_W-1:0] root;
   } root_type;

   typedef struct packed {
      logic [MARGIN_W-1:0] rem;
      logic [CHAN_W-1:0]   quo;
   } div_type;

   // One digit of the floor square root; k counts from the top pair of bits
   function automatic root_type root_step(input root_type s, input int k);
      logic [RACC_W-1:0] bitv;
      logic [RACC_W-1:0] trial;
      root_type          r;
      bitv  = RACC_W'(1) << (ROOT_TOP - 2 * k);
      trial = s.root + bitv;
      if ({1'b0, s.rem} >= trial) begin
         r.rem  = s.rem - trial[REM_W-1:0];
         r.root = (s.root >> 1) + bitv;
      end else begin
         r.rem  = s.rem;
         r.root = s.root >> 1;
      end
      return r;
   endfunction

   // One quotient bit of a restoring divide; k counts from the top bit
   function automatic div_type div_step(input div_type s, input logic [CHAN_W-1:0] num,
                                        input logic [MARGIN_W-1:0] den, input int k);
      logic [MARGIN_W:0]     trial;
      logic [CHAN_W-1:0]     qbit;
      div_type               r;
      qbit  = CHAN_W'(1) << (DIV_STEPS - 1 - k);
      trial = {s.rem, |(num & qbit)};
      if (trial >= {1'b0, den}) begin
         r.rem = MARGIN_W'(trial - {1'b0, den});
         r.quo = s.quo | qbit;
      end else begin
         r.rem = trial[MARGIN_W-1:0];
         r.quo = s.quo;
      end
      return r;
   endfunction

endpackage

// ----- rtl/bpc_req_if.sv -----
// Input channel: pixel coordinate and sampled source pixel.
interface bpc_req_if import bpc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [COORD_W-1:0]  pixel_x;
   logic [COORD_W-1:0]  pixel_y;
   logic [PIX_W-1:0]    src_pixel;
   logic                src_outside;

   modport source (output valid, pixel_x, pixel_y, src_pixel, src_outside, input ready);
   modport sink (input valid, pixel_x, pixel_y, src_pixel, src_outside, output ready);
endinterface

// ----- rtl/bpc_rsp_if.sv -----
// Result channel: composited pixel and its region code.
interface bpc_rsp_if import bpc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PIX_W-1:0]    out_pixel;
   logic [REGION_W-1:0] region;

   modport source (output valid, out_pixel, region, input ready);
   modport sink (input valid, out_pixel, region, output ready);
endinterface

// ----- rtl/bpc_csr_if.sv -----
// Configuration write channel: register index and write data.
interface bpc_csr_if import bpc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [PIX_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/bpc_csr.sv -----
// Configuration register file of the compositor.
module bpc_csr import bpc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [CSR_IDX_W-1:0] wr_index,
   input  logic [PIX_W-1:0]     wr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; drop unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index_type'(wr_index))
            CSR_FRAME_WIDTH:     cfg_in.frame_width     = wr_data[DIM_W-1:0];
            CSR_FRAME_HEIGHT:    cfg_in.frame_height    = wr_data[DIM_W-1:0];
            CSR_MARGIN_WIDTH:    cfg_in.margin_width    = wr_data[MARGIN_W-1:0];
            CSR_GRADIENT_WIDTH:  cfg_in.gradient_width  = wr_data[MARGIN_W-1:0];
            CSR_BG_COLOUR:       cfg_in.bg_colour       = wr_data;
            CSR_BACKDROP_COLOUR: cfg_in.backdrop_colour = wr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width     <= FRAME_WIDTH_RST;
         cfg_ff.frame_height    <= FRAME_HEIGHT_RST;
         cfg_ff.margin_width    <= '0;
         cfg_ff.gradient_width  <= '0;
         cfg_ff.bg_colour       <= '0;
         cfg_ff.backdrop_colour <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/bpc_front.sv -----
// Front stages: capture, frame bounds, region sort, squares and their sum.
module bpc_front import bpc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [COORD_W-1:0] pixel_x,
   input  logic [COORD_W-1:0] pixel_y,
   input  logic [PIX_W-1:0]   src_pixel,
   input  logic               src_outside,
   input  cfg_type            cfg,
   output logic               out_valid,
   output logic [SUM_W-1:0]   out_sum,
   output side_type           out_side
);

   // Stage A: input capture
   logic               a_v_ff;
   logic [COORD_W-1:0] a_x_ff;
   logic [COORD_W-1:0] a_y_ff;
   logic [PIX_W-1:0]   a_src_ff;
   logic               a_out_ff;

   // Stage B: source pixel and frame bounds
   logic               b_v_ff;
   logic [COORD_W-1:0] b_x_ff;
   logic [COORD_W-1:0] b_y_ff;
   logic [PIX_W-1:0]   b_pix_ff;
   logic [PIX_W-1:0]   b_pix_in;
   lim_type            b_lim_ff;
   lim_type            b_lim_in;

   // Stage C: region and edge distances
   logic              c_v_ff;
   logic [DIST_W-1:0] c_dx_ff;
   logic [DIST_W-1:0] c_dy_ff;
   logic [DIST_W-1:0] c_dx_in;
   logic [DIST_W-1:0] c_dy_in;
   side_type          c_side_ff;
   side_type          c_side_in;

   // Stage D: squares
   logic            d_v_ff;
   logic [SQ_W-1:0] d_sqx_ff;
   logic [SQ_W-1:0] d_sqy_ff;
   logic [SQ_W-1:0] d_sqx_in;
   logic [SQ_W-1:0] d_sqy_in;
   side_type        d_side_ff;

   // Stage E: sum of squares
   logic             e_v_ff;
   logic [SUM_W-1:0] e_sum_ff;
   logic [SUM_W-1:0] e_sum_in;
   side_type         e_side_ff;

   logic [DIM_W-1:0]    w;
   logic [DIM_W-1:0]    h;
   logic [MARGIN_W-1:0] n;
   logic [LIM_W-1:0]    xs;
   logic [LIM_W-1:0]    ys;
   logic [LIM_W-1:0]    dxa;
   logic [LIM_W-1:0]    dya;
   logic                in_x;
   logic                in_y;
   logic                ring;

   // Stage B: pick the source, saturate the frame and form the bounds
   always_comb begin
      b_pix_in = a_out_ff ? cfg.backdrop_colour : a_src_ff;
      w = (cfg.frame_width  > DIM_CAP) ? DIM_CAP : cfg.frame_width;
      h = (cfg.frame_height > DIM_CAP) ? DIM_CAP : cfg.frame_height;
      n = (cfg.margin_width > cfg.gradient_width) ?
          MARGIN_W'(cfg.margin_width - cfg.gradient_width) : '0;
      b_lim_in.xm = LIM_W'(w) - LIM_W'(cfg.margin_width);
      b_lim_in.ym = LIM_W'(h) - LIM_W'(cfg.margin_width);
      b_lim_in.xn = LIM_W'(w) - LIM_W'(n);
      b_lim_in.yn = LIM_W'(h) - LIM_W'(n);
      b_lim_in.n  = n;
   end

   // Stage C: sort into regions and measure distance to the inner box
   always_comb begin
      xs   = LIM_W'(b_x_ff);
      ys   = LIM_W'(b_y_ff);
      in_x = (COORD_W'(cfg.margin_width) <= b_x_ff) && ($signed(xs) < $signed(b_lim_ff.xm));
      in_y = (COORD_W'(cfg.margin_width) <= b_y_ff) && ($signed(ys) < $signed(b_lim_ff.ym));
      ring = (cfg.gradient_width != '0) &&
             (COORD_W'(b_lim_ff.n) <= b_x_ff) && ($signed(xs) < $signed(b_lim_ff.xn)) &&
             (COORD_W'(b_lim_ff.n) <= b_y_ff) && ($signed(ys) < $signed(b_lim_ff.yn));
      dxa = (b_x_ff < COORD_W'(cfg.margin_width)) ?
            (LIM_W'(cfg.margin_width) - xs) : (xs - b_lim_ff.xm);
      dya = (b_y_ff < COORD_W'(cfg.margin_width)) ?
            (LIM_W'(cfg.margin_width) - ys) : (ys - b_lim_ff.ym);
      c_dx_in = dxa[LIM_W-1] ? '0 : dxa[DIST_W-1:0];
      c_dy_in = dya[LIM_W-1] ? '0 : dya[DIST_W-1:0];
      c_side_in.pix      = b_pix_ff;
      c_side_in.corner   = !in_x && !in_y;
      c_side_in.lin_dist = in_x ? c_dy_in : c_dx_in;
      if (in_x && in_y) begin
         c_side_in.region = REGION_INNER;
      end else if (ring) begin
         c_side_in.region = REGION_RING;
      end else begin
         c_side_in.region = REGION_OUTER;
      end
   end

   // Stages D and E: squares, then their sum
   assign d_sqx_in = SQ_W'(c_dx_ff) * SQ_W'(c_dx_ff);
   assign d_sqy_in = SQ_W'(c_dy_ff) * SQ_W'(c_dy_ff);
   assign e_sum_in = SUM_W'(d_sqx_ff) + SUM_W'(d_sqy_ff);

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= in_valid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff;
         e_v_ff <= d_v_ff;
      end
   end

   // Advance payload; hold on stall
   always_ff @(posedge clock) begin
      if (en) begin
         a_x_ff    <= pixel_x;
         a_y_ff    <= pixel_y;
         a_src_ff  <= src_pixel;
         a_out_ff  <= src_outside;
         b_x_ff    <= a_x_ff;
         b_y_ff    <= a_y_ff;
         b_pix_ff  <= b_pix_in;
         b_lim_ff  <= b_lim_in;
         c_dx_ff   <= c_dx_in;
         c_dy_ff   <= c_dy_in;
         c_side_ff <= c_side_in;
         d_sqx_ff  <= d_sqx_in;
         d_sqy_ff  <= d_sqy_in;
         d_side_ff <= c_side_ff;
         e_sum_ff  <= e_sum_in;
         e_side_ff <= d_side_ff;
      end
   end

   assign out_valid = e_v_ff;
   assign out_sum   = e_sum_ff;
   assign out_side  = e_side_ff;

endmodule

// ----- rtl/bpc_root.sv -----
// Pipelined floor square root, with the alpha ramp step divide alongside.
module bpc_root import bpc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  cfg_type           cfg,
   input  logic              in_valid,
   input  logic [SUM_W-1:0]  in_sum,
   input  side_type          in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output logic [CHAN_W-1:0] out_step,
   output side_type          out_side
);

   logic [ROOT_STAGES-1:0] v_ff;
   logic [ROOT_STAGES-1:0] v_in;
   root_type               rt_ff  [ROOT_STAGES];
   root_type               rt_in  [ROOT_STAGES];
   root_type               rt_src [ROOT_STAGES];
   div_type                dv_ff  [ROOT_STAGES];
   div_type                dv_in  [ROOT_STAGES];
   div_type                dv_src [ROOT_STAGES];
   side_type               sd_ff  [ROOT_STAGES];
   side_type               sd_in  [ROOT_STAGES];
   logic [CHAN_W-1:0]      num;

   // Ramp span: room left above the background alpha
   assign num = CHAN_W'(8'd255 - cfg.bg_colour[PIX_W-1 -: CHAN_W]);

   // Each stage runs up to two root digits and two quotient bits
   always_comb begin
      rt_src[0].rem  = in_sum;
      rt_src[0].root = '0;
      dv_src[0]      = '0;
      sd_in[0]       = in_side;
      for (int s = 1; s < ROOT_STAGES; s++) begin
         rt_src[s] = rt_ff[s-1];
         dv_src[s] = dv_ff[s-1];
         sd_in[s]  = sd_ff[s-1];
      end
      for (int s = 0; s < ROOT_STAGES; s++) begin
         rt_in[s] = rt_src[s];
         dv_in[s] = dv_src[s];
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            if (s * STEPS_PER_STAGE + j < ROOT_STEPS) begin
               rt_in[s] = root_step(rt_in[s], s * STEPS_PER_STAGE + j);
            end
            if (s * STEPS_PER_STAGE + j < DIV_STEPS) begin
               dv_in[s] = div_step(dv_in[s], num, cfg.gradient_width,
                                   s * STEPS_PER_STAGE + j);
            end
         end
      end
   end

   assign v_in = {v_ff[ROOT_STAGES-2:0], in_valid};

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   // Advance payload; hold on stall
   always_ff @(posedge clock) begin
      if (en) begin
         rt_ff <= rt_in;
         dv_ff <= dv_in;
         sd_ff <= sd_in;
      end
   end

   assign out_valid = v_ff[ROOT_STAGES-1];
   assign out_root  = rt_ff[ROOT_STAGES-1].root[ROOT_W-1:0];
   assign out_step  = dv_ff[ROOT_STAGES-1].quo;
   assign out_side  = sd_ff[ROOT_STAGES-1];

endmodule

// ----- rtl/bpc_blend.sv -----
// Back stages: ring alpha, channel weights and the alpha blend.
module bpc_blend import bpc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  cfg_type           cfg,
   input  logic              in_valid,
   input  logic [ROOT_W-1:0] in_root,
   input  logic [CHAN_W-1:0] in_step,
   input  side_type          in_side,
   output logic              out_valid,
   output logic [PIX_W-1:0]  out_pixel,
   output region_type        out_region
);

   localparam int NCH = 3;

   // Stage F: distance test and ramp product
   logic              f_v_ff;
   logic              f_blend_ff;
   logic              f_blend_in;
   logic [CHAN_W-1:0] f_prod_ff;
   logic [CHAN_W-1:0] f_prod_in;
   logic [PIX_W-1:0]  f_pix_ff;
   region_type        f_region_ff;

   // Stage G: weighted channels
   logic                      g_v_ff;
   logic                      g_blend_ff;
   logic [PIX_W-1:0]          g_pix_ff;
   region_type                g_region_ff;
   logic [NCH-1:0][15:0]      g_pf_ff;
   logic [NCH-1:0][15:0]      g_pf_in;
   logic [NCH-1:0][16:0]      g_pb_ff;
   logic [NCH-1:0][16:0]      g_pb_in;

   // Stage H: result
   logic             h_v_ff;
   logic [PIX_W-1:0] h_pix_ff;
   logic [PIX_W-1:0] h_pix_in;
   region_type       h_region_ff;

   logic [ROOT_W-1:0]   ring_dist;
   logic [2*CHAN_W-1:0] prod_full;
   logic                in_reach;
   logic [CHAN_W-1:0]   bg_alpha;
   logic [CHAN_W-1:0]   alpha;
   logic [CHAN_W-1:0]   wf;
   logic [CHAN_W:0]     wb;
   logic [16:0]         csum [NCH];

   assign bg_alpha = cfg.bg_colour[PIX_W-1 -: CHAN_W];

   // Stage F: pick the distance, test it against the ring width
   always_comb begin
      ring_dist  = in_side.corner ? in_root : ROOT_W'(in_side.lin_dist);
      in_reach   = ring_dist <= ROOT_W'(cfg.gradient_width);
      prod_full  = (2*CHAN_W)'(in_step) * (2*CHAN_W)'(ring_dist[CHAN_W-1:0]);
      f_prod_in  = prod_full[CHAN_W-1:0];
      f_blend_in = (in_side.region == REGION_INNER) ||
                   ((in_side.region == REGION_RING) && in_reach);
   end

   // Stage G: blend weights times each channel
   always_comb begin
      alpha = (f_region_ff == REGION_INNER) ? bg_alpha : CHAN_W'(bg_alpha + f_prod_ff);
      wf    = CHAN_W'(8'd255 - alpha);
      wb    = (CHAN_W+1)'(alpha) + 9'd1;
      for (int c = 0; c < NCH; c++) begin
         g_pf_in[c] = 16'(wf) * 16'(cfg.bg_colour[8*c +: 8]);
         g_pb_in[c] = 17'(wb) * 17'(f_pix_ff[8*c +: 8]);
      end
   end

   // Stage H: sum, scale down and select pass-through
   always_comb begin
      h_pix_in = g_pix_ff;
      for (int c = 0; c < NCH; c++) begin
         csum[c] = 17'(g_pf_ff[c]) + g_pb_ff[c];
      end
      if (g_blend_ff) begin
         h_pix_in = {8'h00, csum[2][15:8], csum[1][15:8], csum[0][15:8]};
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
         g_v_ff <= 1'b0;
         h_v_ff <= 1'b0;
      end else if (en) begin
         f_v_ff <= in_valid;
         g_v_ff <= f_v_ff;
         h_v_ff <= g_v_ff;
      end
   end

   // Advance payload; hold on stall
   always_ff @(posedge clock) begin
      if (en) begin
         f_blend_ff  <= f_blend_in;
         f_prod_ff   <= f_prod_in;
         f_pix_ff    <= in_side.pix;
         f_region_ff <= in_side.region;
         g_blend_ff  <= f_blend_ff;
         g_pix_ff    <= f_pix_ff;
         g_region_ff <= f_region_ff;
         g_pf_ff     <= g_pf_in;
         g_pb_ff     <= g_pb_in;
         h_pix_ff    <= h_pix_in;
         h_region_ff <= g_region_ff;
      end
   end

   assign out_valid  = h_v_ff;
   assign out_pixel  = h_pix_ff;
   assign out_region = h_region_ff;

endmodule

// ----- rtl/background_pixel_compositor_core.sv -----
// Top level of the background pixel compositor: pipeline, output register and skid.
//
// Usage:
//   req_chan carries one pixel per transfer: pixel_x, pixel_y, the sampled
//   ARGB src_pixel and src_outside, which swaps in the backdrop colour.
//   rsp_chan returns one result per pixel, in order: out_pixel and region
//   (outer band, gradient ring, inner box).
//   csr_chan writes the six configuration registers by index; it is always
//   ready. Write it only while no pixel is in flight.
// Timing:
//   One pixel is taken per cycle while req_chan.ready is high. Each input
//   passes five front stages, seven square-root stages (up to two digits
//   each) and three blend stages, then the output register, to rsp_chan.
// Reset:
//   Synchronous. Clears all valid bits, so the pipeline comes up empty, and
//   loads frame 1024 x 768 with all other configuration registers zero.
// Stall:
//   When rsp_chan stalls, one more result lands in a skid register; after
//   that req_chan.ready drops and the whole pipeline holds until the skid
//   drains. No item is dropped or repeated.
module background_pixel_compositor_core import bpc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   bpc_req_if.sink         req_chan,
   bpc_rsp_if.source       rsp_chan,
   bpc_csr_if.sink         csr_chan
);

   cfg_type           cfg;
   logic              en;

   logic              fr_valid;
   logic [SUM_W-1:0]  fr_sum;
   side_type          fr_side;

   logic              rt_valid;
   logic [ROOT_W-1:0] rt_root;
   logic [CHAN_W-1:0] rt_step;
   side_type          rt_side;

   logic              bl_valid;
   logic [PIX_W-1:0]  bl_pixel;
   region_type        bl_region;

   logic              out_v_ff;
   logic              out_v_in;
   logic [PIX_W-1:0]  out_pix_ff;
   logic [PIX_W-1:0]  out_pix_in;
   region_type        out_reg_ff;
   region_type        out_reg_in;
   logic              skid_v_ff;
   logic              skid_v_in;
   logic [PIX_W-1:0]  skid_pix_ff;
   logic [PIX_W-1:0]  skid_pix_in;
   region_type        skid_reg_ff;
   region_type        skid_reg_in;
   logic              push;

   // Pipeline moves while the skid register is empty
   assign en             = !skid_v_ff;
   assign req_chan.ready = en;
   assign csr_chan.ready = 1'b1;

   bpc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_chan.valid),
      .wr_index (csr_chan.index),
      .wr_data  (csr_chan.data),
      .cfg      (cfg)
   );

   bpc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_chan.valid),
      .pixel_x     (req_chan.pixel_x),
      .pixel_y     (req_chan.pixel_y),
      .src_pixel   (req_chan.src_pixel),
      .src_outside (req_chan.src_outside),
      .cfg         (cfg),
      .out_valid   (fr_valid),
      .out_sum     (fr_sum),
      .out_side    (fr_side)
   );

   bpc_root u_root (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg),
      .in_valid  (fr_valid),
      .in_sum    (fr_sum),
      .in_side   (fr_side),
      .out_valid (rt_valid),
      .out_root  (rt_root),
      .out_step  (rt_step),
      .out_side  (rt_side)
   );

   bpc_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .cfg        (cfg),
      .in_valid   (rt_valid),
      .in_root    (rt_root),
      .in_step    (rt_step),
      .in_side    (rt_side),
      .out_valid  (bl_valid),
      .out_pixel  (bl_pixel),
      .out_region (bl_region)
   );

   // Output register with skid: refill from skid first, else from the pipeline
   assign push = en && bl_valid;

   always_comb begin
      out_v_in    = out_v_ff;
      out_pix_in  = out_pix_ff;
      out_reg_in  = out_reg_ff;
      skid_v_in   = skid_v_ff;
      skid_pix_in = skid_pix_ff;
      skid_reg_in = skid_reg_ff;
      if (!out_v_ff || rsp_chan.ready) begin
         if (skid_v_ff) begin
            out_v_in   = 1'b1;
            out_pix_in = skid_pix_ff;
            out_reg_in = skid_reg_ff;
            skid_v_in  = 1'b0;
         end else begin
            out_v_in   = push;
            out_pix_in = bl_pixel;
            out_reg_in = bl_region;
         end
      end else if (push) begin
         skid_v_in   = 1'b1;
         skid_pix_in = bl_pixel;
         skid_reg_in = bl_region;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_pix_ff  <= out_pix_in;
      out_reg_ff  <= out_reg_in;
      skid_pix_ff <= skid_pix_in;
      skid_reg_ff <= skid_reg_in;
   end

   assign rsp_chan.valid     = out_v_ff;
   assign rsp_chan.out_pixel = out_pix_ff;
   assign rsp_chan.region    = out_reg_ff;

   // Skid fills only behind a held result
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(rsp_chan.valid && !rsp_chan.ready))
      else $error("skid register filled without a stalled result");

   // A full skid always sits behind a presented result
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> rsp_chan.valid)
      else $error("skid register holds data while the output is empty");

   // Inner box results are blended, so their alpha byte is clear
   a_inner_alpha: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.region == REGION_INNER)) |->
         (rsp_chan.out_pixel[31:24] == 8'h00))
      else $error("inner box result with nonzero alpha byte");

endmodule
